FILE: src/kvt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kvt_pkg
// Shared types and constants for the key/value table core.
// ----------------------------------------------------------------------------
package kvt_pkg;

    localparam int KVT_CAPACITY = 64;
    localparam int KEY_W        = 32;
    localparam int VAL_W        = 32;
    localparam int TOTAL_W      = 7;

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_LOOKUP = 2'd1,
        KIND_REMOVE = 2'd2,
        KIND_CLEAR  = 2'd3
    } kvt_kind_t;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_FULL    = 2'd1,
        STATUS_MISSING = 2'd2
    } kvt_status_t;

    typedef struct packed {
        kvt_kind_t         kind;
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  value;
    } kvt_cmd_t;

    typedef struct packed {
        logic compare;
        logic apply;
        logic hit;
        logic full;
    } kvt_ctrl_t;

endpackage
`default_nettype wire

FILE: src/key_value_table_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// key_value_table_core
// Associative table of unique keys with values, kept in insertion order in a
// row of slot cells. Insert, lookup, remove with gap closing, and clear.
// ----------------------------------------------------------------------------
// The accepted item is registered, compared in every cell in the match step,
// then applied and its result registered in the apply step. The next item is
// accepted in the apply step; a full output register stalls the apply step.
// Reset clears the entry count and handshake state; slot contents are not
// cleared and are only read below the entry count.
module key_value_table_core
    import kvt_pkg::*;
#(
    parameter int CAPACITY = KVT_CAPACITY
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // key[31:0], value[63:32]
    input  wire logic [1:0]  s_tuser,   // kind[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata    // found[0], read_value[32:1], status[34:33],
                                        // is_empty[35], entry_total[42:36], zero[47:43]
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int EXT_W = (CNT_W > TOTAL_W) ? CNT_W : TOTAL_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_APPLY
    } state_t;

    state_t           state_reg;
    kvt_cmd_t         cmd_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             m_tvalid_reg;
    logic [47:0]      m_tdata_reg;

    kvt_ctrl_t        ctrl;
    logic             out_free;
    logic             s_fire;
    logic             apply_go;
    logic             hit;
    logic             full;
    logic [VAL_W-1:0] rd_or;
    logic [VAL_W-1:0] read_value;
    kvt_status_t      status;
    logic             found;
    logic [EXT_W-1:0] count_ext;

    logic [KEY_W-1:0] cell_key   [CAPACITY];
    logic [VAL_W-1:0] cell_value [CAPACITY];
    logic [CAPACITY-1:0] cell_match;
    logic [CAPACITY:0]   shift_chain;

    assign out_free = !m_tvalid_reg || m_tready;
    assign apply_go = (state_reg == ST_APPLY) && out_free;
    assign s_tready = (state_reg == ST_IDLE) || apply_go;
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign full = count_reg == CNT_W'(CAPACITY);
    assign hit  = (|cell_match) && (cmd_reg.kind != KIND_CLEAR);

    assign ctrl.compare = state_reg == ST_MATCH;
    assign ctrl.apply   = apply_go;
    assign ctrl.hit     = hit;
    assign ctrl.full    = full;

    assign shift_chain[0] = 1'b0;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        kvt_cell #(
            .CNT_W (CNT_W),
            .INDEX (i)
        ) u_cell (
            .aclk       (aclk),
            .cmd        (cmd_reg),
            .ctrl       (ctrl),
            .count      (count_reg),
            .next_key   ((i + 1 < CAPACITY) ? cell_key[(i + 1) % CAPACITY]
                                            : cell_key[i]),
            .next_value ((i + 1 < CAPACITY) ? cell_value[(i + 1) % CAPACITY]
                                            : cell_value[i]),
            .shift_in   (shift_chain[i]),
            .shift_out  (shift_chain[i + 1]),
            .match      (cell_match[i]),
            .key        (cell_key[i]),
            .value      (cell_value[i])
        );
    end

    always_comb begin
        rd_or = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            rd_or = rd_or | (cell_match[i] ? cell_value[i] : '0);
        end
    end

    always_comb begin
        count_next = count_reg;
        status     = STATUS_OK;
        read_value = '1;
        found      = hit;
        case (cmd_reg.kind)
            KIND_INSERT: begin
                if (!hit) begin
                    if (full) begin
                        status = STATUS_FULL;
                    end else begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
            end
            KIND_LOOKUP: begin
                if (hit) begin
                    read_value = rd_or;
                end
            end
            KIND_REMOVE: begin
                if (hit) begin
                    count_next = count_reg - CNT_W'(1);
                end else begin
                    status = STATUS_MISSING;
                end
            end
            KIND_CLEAR: begin
                count_next = '0;
                found      = 1'b0;
            end
            default: begin
            end
        endcase
    end

    assign count_ext = EXT_W'(count_next);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (s_fire) begin
                cmd_reg.kind  <= kvt_kind_t'(s_tuser);
                cmd_reg.key   <= s_tdata[KEY_W-1:0];
                cmd_reg.value <= s_tdata[KEY_W+VAL_W-1:KEY_W];
            end
            if (apply_go) begin
                m_tvalid_reg <= 1'b1;
                count_reg    <= count_next;
                m_tdata_reg  <= {5'b0, count_ext[TOTAL_W-1:0], count_next == '0,
                                 status, read_value, found};
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        state_reg <= ST_MATCH;
                    end
                end
                ST_MATCH: begin
                    state_reg <= ST_APPLY;
                end
                ST_APPLY: begin
                    if (out_free) begin
                        state_reg <= s_tvalid ? ST_MATCH : ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: src/kvt_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kvt_cell
// One table slot: holds a key/value pair, compares it against the command key
// and takes its right neighbor's pair when it or an earlier slot is removed.
// ----------------------------------------------------------------------------
module kvt_cell
    import kvt_pkg::*;
#(
    parameter int CNT_W = 7,
    parameter int INDEX = 0
) (
    input  wire logic             aclk,
    input  wire kvt_cmd_t         cmd,
    input  wire kvt_ctrl_t        ctrl,
    input  wire logic [CNT_W-1:0] count,
    input  wire logic [KEY_W-1:0] next_key,
    input  wire logic [VAL_W-1:0] next_value,
    input  wire logic             shift_in,
    output logic                  shift_out,
    output logic                  match,
    output logic [KEY_W-1:0]      key,
    output logic [VAL_W-1:0]      value
);

    localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);

    logic [KEY_W-1:0] key_reg;
    logic [VAL_W-1:0] value_reg;
    logic             match_reg;
    logic             occupied;
    logic             is_tail;

    assign occupied  = IDX < count;
    assign is_tail   = IDX == count;
    assign shift_out = shift_in | match_reg;
    assign match     = match_reg;
    assign key       = key_reg;
    assign value     = value_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.compare) begin
            match_reg <= occupied && (key_reg == cmd.key);
        end
        if (ctrl.apply) begin
            case (cmd.kind)
                KIND_INSERT: begin
                    if (ctrl.hit && match_reg) begin
                        value_reg <= cmd.value;
                    end else if (!ctrl.hit && !ctrl.full && is_tail) begin
                        key_reg   <= cmd.key;
                        value_reg <= cmd.value;
                    end
                end
                KIND_REMOVE: begin
                    if (ctrl.hit && shift_out) begin
                        key_reg   <= next_key;
                        value_reg <= next_value;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule
`default_nettype wire
